// ----- rtl/accumulator_machine_step_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef ACCUMULATOR_MACHINE_STEP_UNIT_ASSERT_SVH
`define ACCUMULATOR_MACHINE_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define AMSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amsu assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define AMSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amsu assertion failed");

`endif

// ----- rtl/amsu_pkg.sv -----
`timescale 1ns / 1ps

package amsu_pkg;

  // Fixed field widths of the channels
  localparam int OP_W      = 4;
  localparam int SLOT_W    = 5;
  localparam int FIELD_W   = 32;
  localparam int SLOT_REGS = 3;  // A, B and counter come before the memory words

  localparam logic [SLOT_W-1:0] SLOT_A   = 5'd0;
  localparam logic [SLOT_W-1:0] SLOT_B   = 5'd1;
  localparam logic [SLOT_W-1:0] SLOT_CNT = 5'd2;

  typedef enum logic [OP_W-1:0] {
    OP_NOP   = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_A2B   = 4'd5,
    OP_B2A   = 4'd6,
    OP_LDA   = 4'd7,
    OP_LDB   = 4'd8,
    OP_MEMW  = 4'd9,
    OP_DEC   = 4'd10,
    OP_INC   = 4'd11,
    OP_CLR   = 4'd12,
    OP_DUMP  = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_COMMIT,
    ST_DUMP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic              exec;    // execute accepted opcode
    logic              start;   // load iterative mul/div unit
    logic              step;    // one mul/div iteration
    logic              commit;  // write mul/div result into A
    logic              emit;    // load output register with slot below
    logic [SLOT_W-1:0] slot;
  } amsu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic b_zero;
    logic out_free;
  } amsu_stat_t;

endpackage

// ----- rtl/accumulator_machine_step_unit.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Ports                                            | Transfer
// in      | input     | in_func, in_value, in_addr, in_mem_data          | in_valid & !in_stall
// out     | output    | out_slot, out_word, out_div_fault, out_last      | out_valid & !out_stall
//
// Register, memory and counter opcodes act when accepted; the next item can follow at once.
// Multiply and divide run one bit per cycle in ST_ITER and then write A back in ST_COMMIT;
// a divide by zero only sets the fault flag and does not start the mul/div unit.
// A dump makes MEM_WORDS + 3 transfers (18), one per cycle while out_stall is low, and
// takes the input again once the final result sits in the output register.
// Synchronous reset clears all but the payload registers; in_stall is high while an item runs.

module accumulator_machine_step_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int MEM_WORDS  = 15,
  parameter int WORD_BITS  = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [amsu_pkg::OP_W-1:0]            in_func,
  input  logic signed [amsu_pkg::FIELD_W-1:0]  in_value,
  input  logic [3:0]                           in_addr,
  input  logic [3:0]                           in_mem_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [amsu_pkg::SLOT_W-1:0]          out_slot,
  output logic signed [amsu_pkg::FIELD_W-1:0]  out_word,
  output logic                                 out_div_fault,
  output logic                                 out_last
);
  import amsu_pkg::*;

  amsu_cmd_t  cmd;
  amsu_stat_t stat;

  // Sequencer
  amsu_ctrl #(
    .DATA_WIDTH (DATA_WIDTH),
    .MEM_WORDS  (MEM_WORDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Registers, memory, mul/div unit and output register
  amsu_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .MEM_WORDS  (MEM_WORDS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_func       (in_func),
    .in_value      (in_value),
    .in_addr       (in_addr),
    .in_mem_data   (in_mem_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_slot      (out_slot),
    .out_word      (out_word),
    .out_div_fault (out_div_fault),
    .out_last      (out_last)
  );

endmodule

// ----- rtl/amsu_ctrl.sv -----
`timescale 1ns / 1ps

module amsu_ctrl #(
  parameter int DATA_WIDTH = 32,
  parameter int MEM_WORDS  = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [amsu_pkg::OP_W-1:0]         in_func,
  output logic                              in_stall,
  input  amsu_pkg::amsu_stat_t              stat,
  output amsu_pkg::amsu_cmd_t               cmd
);
  import amsu_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(DATA_WIDTH - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MEM_WORDS + SLOT_REGS - 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              accept;
  op_t               op;

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    slot_nxt  = slot_r;
    op        = op_t'(in_func);
    in_stall  = (state_r != ST_IDLE);
    accept    = in_valid && !in_stall;
    cmd       = '0;
    cmd.slot  = slot_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.exec = 1'b1;
          case (op)
            OP_MUL: begin
              cmd.start = 1'b1;
            end
            OP_DIV: begin
              // divide by zero only sets the sticky flag
              cmd.start = !stat.b_zero;
            end
            OP_DUMP: begin
              slot_nxt  = SLOT_A;
              state_nxt = ST_DUMP;
            end
            default: ;
          endcase
          if (cmd.start) begin
            cnt_nxt   = '0;
            state_nxt = ST_ITER;
          end
        end
      end
      ST_ITER: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_DUMP: begin
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          if (slot_r == SLOT_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/amsu_dp.sv -----
`timescale 1ns / 1ps

module amsu_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int MEM_WORDS  = 15,
  parameter int WORD_BITS  = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  amsu_pkg::amsu_cmd_t                  cmd,
  output amsu_pkg::amsu_stat_t                 stat,
  input  logic [amsu_pkg::OP_W-1:0]            in_func,
  input  logic signed [amsu_pkg::FIELD_W-1:0]  in_value,
  input  logic [3:0]                           in_addr,
  input  logic [3:0]                           in_mem_data,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [amsu_pkg::SLOT_W-1:0]          out_slot,
  output logic signed [amsu_pkg::FIELD_W-1:0]  out_word,
  output logic                                 out_div_fault,
  output logic                                 out_last
);
  import amsu_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int MA_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MEM_WORDS + SLOT_REGS - 1);

  // Architectural state
  logic [W-1:0]         acc_a_r, acc_a_nxt;
  logic [W-1:0]         acc_b_r, acc_b_nxt;
  logic [W-1:0]         cnt_r, cnt_nxt;
  logic                 fault_r, fault_nxt;
  logic [WORD_BITS-1:0] mem_r [MEM_WORDS];

  // Iterative mul/div unit
  logic [W-1:0] work_r, work_nxt;    // product or remainder
  logic [W-1:0] shift_r, shift_nxt;  // multiplier or dividend/quotient
  logic [W-1:0] opnd_r, opnd_nxt;    // multiplicand or divisor
  logic         is_div_r, is_div_nxt;
  logic         neg_r, neg_nxt;

  // Output register
  logic                      out_valid_r;
  logic [SLOT_W-1:0]         out_slot_r;
  logic signed [FIELD_W-1:0] out_word_r;
  logic                      out_fault_r;
  logic                      out_last_r;

  op_t                  op;
  logic [W-1:0]         value_ext;
  logic                 a_neg, b_neg;
  logic [W-1:0]         a_mag, b_mag;
  logic [W:0]           div_shifted, div_diff;
  logic [W-1:0]         div_rem;
  logic                 wr_en;
  logic [MA_W-1:0]      wr_idx, rd_idx;
  logic [15:0]          wr_data_ext;
  logic [WORD_BITS-1:0] wr_data;
  logic [FIELD_W-1:0]   word_sel;

  assign op        = op_t'(in_func);
  assign value_ext = W'(in_value);
  assign a_neg     = acc_a_r[W-1];
  assign b_neg     = acc_b_r[W-1];
  assign a_mag     = a_neg ? (~acc_a_r + 1'b1) : acc_a_r;
  assign b_mag     = b_neg ? (~acc_b_r + 1'b1) : acc_b_r;

  assign stat.b_zero   = (acc_b_r == '0);
  assign stat.out_free = !out_valid_r || !out_stall;

  // Restoring divide step on magnitudes
  assign div_shifted = {work_r, shift_r[W-1]};
  assign div_diff    = div_shifted - {1'b0, opnd_r};
  assign div_rem     = div_diff[W] ? div_shifted[W-1:0] : div_diff[W-1:0];

  // Memory write port, addresses 1..MEM_WORDS
  assign wr_en       = cmd.exec && (op == OP_MEMW) && (in_addr != 4'd0) &&
                       (int'(in_addr) <= MEM_WORDS);
  assign wr_idx      = MA_W'(in_addr - 4'd1);
  assign wr_data_ext = 16'(in_mem_data);
  assign wr_data     = wr_data_ext[WORD_BITS-1:0];
  assign rd_idx      = MA_W'(cmd.slot - SLOT_W'(SLOT_REGS));

  // Register file updates
  always_comb begin
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    cnt_nxt   = cnt_r;
    fault_nxt = fault_r;
    if (cmd.exec) begin
      case (op)
        OP_ADD:  acc_a_nxt = acc_a_r + acc_b_r;
        OP_SUB:  acc_a_nxt = acc_a_r - acc_b_r;
        OP_DIV:  fault_nxt = fault_r | stat.b_zero;
        OP_A2B: begin
          acc_b_nxt = acc_a_r;
          acc_a_nxt = '0;
        end
        OP_B2A: begin
          acc_a_nxt = acc_b_r;
          acc_b_nxt = '0;
        end
        OP_LDA:  acc_a_nxt = value_ext;
        OP_LDB:  acc_b_nxt = value_ext;
        OP_DEC:  cnt_nxt   = cnt_r - 1'b1;
        OP_INC:  cnt_nxt   = cnt_r + 1'b1;
        OP_CLR:  cnt_nxt   = '0;
        default: ;
      endcase
    end
    if (cmd.commit) begin
      if (is_div_r) begin
        acc_a_nxt = neg_r ? (~shift_r + 1'b1) : shift_r;
      end else begin
        acc_a_nxt = work_r;
      end
    end
  end

  // Mul/div iteration: one bit per cycle
  always_comb begin
    work_nxt   = work_r;
    shift_nxt  = shift_r;
    opnd_nxt   = opnd_r;
    is_div_nxt = is_div_r;
    neg_nxt    = neg_r;
    if (cmd.start) begin
      is_div_nxt = (op == OP_DIV);
      neg_nxt    = a_neg ^ b_neg;
      work_nxt   = '0;
      if (op == OP_DIV) begin
        shift_nxt = a_mag;
        opnd_nxt  = b_mag;
      end else begin
        shift_nxt = acc_b_r;
        opnd_nxt  = acc_a_r;
      end
    end else if (cmd.step) begin
      if (is_div_r) begin
        work_nxt  = div_rem;
        shift_nxt = {shift_r[W-2:0], ~div_diff[W]};
      end else begin
        if (shift_r[0]) begin
          work_nxt = work_r + opnd_r;
        end
        opnd_nxt  = {opnd_r[W-2:0], 1'b0};
        shift_nxt = {1'b0, shift_r[W-1:1]};
      end
    end
  end

  // Register word select; memory words are read in the payload block
  always_comb begin
    case (cmd.slot)
      SLOT_A:   word_sel = FIELD_W'($signed(acc_a_r));
      SLOT_B:   word_sel = FIELD_W'($signed(acc_b_r));
      SLOT_CNT: word_sel = FIELD_W'($signed(cnt_r));
      default:  word_sel = '0;
    endcase
  end

  // Control and architectural state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_a_r     <= '0;
      acc_b_r     <= '0;
      cnt_r       <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MEM_WORDS; i++) begin
        mem_r[i] <= '0;
      end
    end else begin
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
      cnt_r   <= cnt_nxt;
      fault_r <= fault_nxt;
      if (wr_en) begin
        mem_r[wr_idx] <= wr_data;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    work_r   <= work_nxt;
    shift_r  <= shift_nxt;
    opnd_r   <= opnd_nxt;
    is_div_r <= is_div_nxt;
    neg_r    <= neg_nxt;
    if (cmd.emit) begin
      out_slot_r  <= cmd.slot;
      if (cmd.slot < SLOT_W'(SLOT_REGS)) begin
        out_word_r <= word_sel;
      end else begin
        out_word_r <= FIELD_W'(mem_r[rd_idx]);
      end
      out_fault_r <= (cmd.slot == SLOT_A) ? fault_r : 1'b0;
      out_last_r  <= (cmd.slot == SLOT_LAST);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_word      = out_word_r;
  assign out_div_fault = out_fault_r;
  assign out_last      = out_last_r;

endmodule

// ----- rtl/amsu_chk.sv -----
`timescale 1ns / 1ps
`include "accumulator_machine_step_unit_assert.svh"

module amsu_chk #(
  parameter int MEM_WORDS = 15
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [amsu_pkg::OP_W-1:0]            in_func,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [amsu_pkg::SLOT_W-1:0]          out_slot,
  input logic signed [amsu_pkg::FIELD_W-1:0]  out_word,
  input logic                                 out_div_fault,
  input logic                                 out_last
);
  import amsu_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MEM_WORDS + SLOT_REGS - 1);

  // fault flag only rides on the first dump result
  `AMSU_ASSERT_NOW(a_fault_slot0, out_valid && (out_slot != SLOT_A), !out_div_fault)
  // last marks exactly the final slot
  `AMSU_ASSERT_NOW(a_last_slot, out_valid, out_last == (out_slot == SLOT_LAST))
  `AMSU_ASSERT_NOW(a_slot_range, out_valid, out_slot <= SLOT_LAST)
  // a dump holds off the input side while it runs
  `AMSU_ASSERT_NEXT(a_dump_busy, in_valid && !in_stall && (in_func == OP_DUMP), in_stall)
  `AMSU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind accumulator_machine_step_unit amsu_chk #(
  .MEM_WORDS (MEM_WORDS)
) u_amsu_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_slot      (out_slot),
  .out_word      (out_word),
  .out_div_fault (out_div_fault),
  .out_last      (out_last)
);

// ----- test/accumulator_machine_step_unit_tb.sv -----
`timescale 1ns / 1ps

module accumulator_machine_step_unit_tb;
  import amsu_pkg::*;

  localparam int RANDOM_CMDS  = 223;
  localparam int STUCK_LIMIT  = 2000;  // cycles without any transfer
  localparam int DRAIN_CYCLES = 40;    // longer than a mul/div pass
  localparam int MEM_WORDS    = 15;
  localparam int REPORT_MAX   = 10;

  // Opcodes with no action and no name in the package
  localparam logic [OP_W-1:0] OP_SPARE_D = 4'd13;
  localparam logic [OP_W-1:0] OP_SPARE_E = 4'd14;

  localparam logic signed [FIELD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [FIELD_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct {
    logic [OP_W-1:0]           func;
    logic signed [FIELD_W-1:0] value;
    logic [3:0]                addr;
    logic [3:0]                mem_data;
  } cmd_item_t;

  typedef struct {
    logic [SLOT_W-1:0]         slot;
    logic signed [FIELD_W-1:0] word;
    logic                      div_fault;
    logic                      last;
  } dump_word_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // DUT ports
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           in_func     = OP_NOP;
  logic signed [FIELD_W-1:0] in_value    = '0;
  logic [3:0]                in_addr     = '0;
  logic [3:0]                in_mem_data = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic [SLOT_W-1:0]         out_slot;
  logic signed [FIELD_W-1:0] out_word;
  logic                      out_div_fault;
  logic                      out_last;

  accumulator_machine_step_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_value     (in_value),
    .in_addr      (in_addr),
    .in_mem_data  (in_mem_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_slot     (out_slot),
    .out_word     (out_word),
    .out_div_fault(out_div_fault),
    .out_last     (out_last)
  );

  // Machine state as predicted
  logic signed [FIELD_W-1:0] reg_a = '0;
  logic signed [FIELD_W-1:0] reg_b = '0;
  logic signed [FIELD_W-1:0] evt_cnt = '0;
  logic [3:0]                nib_mem [1:MEM_WORDS];
  logic                      div_zero_seen = 1'b0;

  cmd_item_t  cmd_q[$];
  dump_word_t dump_words_q[$];
  cmd_item_t  cur_cmd;

  int total_cmds   = 0;
  int issued_cnt   = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int dumps_seen   = 0;
  int fail_cnt     = 0;
  int stuck_cycles = 0;
  int send_idle_pct = 28;
  int recv_idle_pct = 58;

  initial begin
    for (int i = 1; i <= MEM_WORDS; i++) nib_mem[i] = '0;
  end

  // Update the machine for one accepted command; a dump queues 18 words
  function automatic void apply_op(cmd_item_t c);
    dump_word_t w;
    case (c.func)
      OP_ADD: reg_a = reg_a + reg_b;
      OP_SUB: reg_a = reg_a - reg_b;
      OP_MUL: reg_a = reg_a * reg_b;
      OP_DIV: begin
        if (reg_b == 0) div_zero_seen = 1'b1;
        else if (reg_a == WORD_MIN && reg_b == -1) reg_a = WORD_MIN;
        else reg_a = reg_a / reg_b;
      end
      OP_A2B: begin
        reg_b = reg_a;
        reg_a = '0;
      end
      OP_B2A: begin
        reg_a = reg_b;
        reg_b = '0;
      end
      OP_LDA: reg_a = c.value;
      OP_LDB: reg_b = c.value;
      OP_MEMW: begin
        if (c.addr >= 1 && c.addr <= MEM_WORDS) nib_mem[c.addr] = c.mem_data;
      end
      OP_DEC: evt_cnt = evt_cnt - 1;
      OP_INC: evt_cnt = evt_cnt + 1;
      OP_CLR: evt_cnt = '0;
      OP_DUMP: begin
        w = '{SLOT_A, reg_a, div_zero_seen, 1'b0};
        dump_words_q.push_back(w);
        w = '{SLOT_B, reg_b, 1'b0, 1'b0};
        dump_words_q.push_back(w);
        w = '{SLOT_CNT, evt_cnt, 1'b0, 1'b0};
        dump_words_q.push_back(w);
        for (int i = 1; i <= MEM_WORDS; i++) begin
          w.slot      = SLOT_W'(SLOT_REGS + i - 1);
          w.word      = {28'd0, nib_mem[i]};
          w.div_fault = 1'b0;
          w.last      = (i == MEM_WORDS);
          dump_words_q.push_back(w);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_cmd(logic [OP_W-1:0] f, logic signed [FIELD_W-1:0] v,
                                  logic [3:0] a, logic [3:0] d);
    cmd_item_t c;
    c = '{f, v, a, d};
    cmd_q.push_back(c);
  endfunction

  // Opcode with don't-care operand fields
  function automatic void add_op(logic [OP_W-1:0] f);
    add_cmd(f, $urandom, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
  endfunction

  // Operand mix: extremes, small magnitudes for useful quotients, full range
  function automatic logic signed [FIELD_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $signed($urandom_range(0, 40)) - 20;
      2: return WORD_MAX;
      3: return WORD_MIN;
      default: return $urandom;
    endcase
  endfunction

  // Driver: holds the payload while stalled, picks the next command otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      send_idle_pct <= 28;
      recv_idle_pct <= 58;
    end else begin
      if (in_valid && !in_stall) begin
        apply_op(cur_cmd);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_cmd = cmd_q.pop_front();
          in_func     <= cur_cmd.func;
          in_value    <= cur_cmd.value;
          in_addr     <= cur_cmd.addr;
          in_mem_data <= cur_cmd.mem_data;
          in_valid    <= 1'b1;
          issued_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      // idle mix per third of the run
      if (issued_cnt < total_cmds / 3) begin
        send_idle_pct <= 28;
        recv_idle_pct <= 58;
      end else if (issued_cnt < 2 * total_cmds / 3) begin
        send_idle_pct <= 58;
        recv_idle_pct <= 28;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: each result transfer against the oldest expected word
  always @(posedge clk) begin : result_check
    dump_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_last) dumps_seen++;
      if (dump_words_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
          $display("%0t: unexpected result slot %0d word %h fault %b last %b",
                   $realtime, out_slot, out_word, out_div_fault, out_last);
      end else begin
        exp_w = dump_words_q.pop_front();
        if (out_slot !== exp_w.slot || out_word !== exp_w.word ||
            out_div_fault !== exp_w.div_fault || out_last !== exp_w.last) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("%0t: mismatch exp slot %0d word %h fault %b last %b, got %0d %h %b %b",
                     $realtime, exp_w.slot, exp_w.word, exp_w.div_fault, exp_w.last,
                     out_slot, out_word, out_div_fault, out_last);
        end
      end
    end
  end

  // Watchdog on transfers of either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Stalled after %0d of %0d commands and %0d result transfers",
                 accepted_cnt, total_cmds, results_seen);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [OP_W-1:0] f;

    // Directed: overflow, min / -1, truncation, divide by zero, store edges,
    // counter wrap, moves and the idle opcodes
    add_cmd(OP_LDA, WORD_MAX, 4'hf, 4'h0);
    add_cmd(OP_LDB, 32'sd1, 4'h0, 4'hf);
    add_op(OP_ADD);
    add_op(OP_DUMP);
    add_cmd(OP_LDB, -32'sd1, 4'h5, 4'ha);
    add_op(OP_DIV);
    add_op(OP_MUL);
    add_op(OP_SUB);
    add_cmd(OP_LDA, -32'sd7, 4'ha, 4'h5);
    add_cmd(OP_LDB, 32'sd2, 4'h3, 4'hc);
    add_op(OP_DIV);
    add_cmd(OP_LDB, 32'sd0, 4'hc, 4'h3);
    add_op(OP_DIV);
    add_cmd(OP_MEMW, $urandom, 4'h0, 4'h5);
    add_cmd(OP_MEMW, $urandom, 4'hf, 4'hf);
    add_cmd(OP_MEMW, $urandom, 4'h1, 4'ha);
    add_op(OP_DEC);
    add_op(OP_INC);
    add_op(OP_DEC);
    add_op(OP_A2B);
    add_op(OP_B2A);
    add_op(OP_NOP);
    add_op(OP_SPARE_D);
    add_op(OP_SPARE_E);
    add_op(OP_DUMP);
    add_op(OP_CLR);
    add_op(OP_DUMP);

    // Random commands, dumps weighted up so the results keep flowing
    repeat (RANDOM_CMDS) begin
      if ($urandom_range(0, 99) < 8) f = OP_DUMP;
      else f = OP_W'($urandom_range(0, 15));
      add_cmd(f, pick_value(), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end
    total_cmds = cmd_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_cmds || dump_words_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    fail_cnt += dump_words_q.size();

    $display("Ran %0d commands with %0d dumps, checked %0d result transfers, %0d failures",
             accepted_cnt, dumps_seen, results_seen, fail_cnt);
    $display("Covered arithmetic wrap, divide by zero, store writes and three stall mixes");
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
